FILE: rtl/qr_pkg.sv
// shared types, constants and the sign table for the quaternion rotation pipeline
`default_nettype none

package qr_pkg;

  // field width of every quaternion component and result
  localparam int DATA_WIDTH = 32;
  // default number of fraction bits of the rotation quaternions
  localparam int ROT_FRAC_BITS = 30;

  // saturation limits of a result component
  localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // input beat
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] left_real;
    logic signed [DATA_WIDTH-1:0] left_i;
    logic signed [DATA_WIDTH-1:0] left_j;
    logic signed [DATA_WIDTH-1:0] left_k;
    logic signed [DATA_WIDTH-1:0] point_real;
    logic signed [DATA_WIDTH-1:0] point_i;
    logic signed [DATA_WIDTH-1:0] point_j;
    logic signed [DATA_WIDTH-1:0] point_k;
    logic signed [DATA_WIDTH-1:0] right_real;
    logic signed [DATA_WIDTH-1:0] right_i;
    logic signed [DATA_WIDTH-1:0] right_j;
    logic signed [DATA_WIDTH-1:0] right_k;
  } qr_in_t;

  // output beat
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] out_real;
    logic signed [DATA_WIDTH-1:0] out_i;
    logic signed [DATA_WIDTH-1:0] out_j;
    logic signed [DATA_WIDTH-1:0] out_k;
    logic                         overflow;
  } qr_out_t;

  // stage enables and valids of one hamilton product pipeline
  typedef struct packed {
    logic en_p;
    logic en_m;
    logic en_s;
    logic v_p;
    logic v_m;
    logic v_s;
  } qr_stage_t;

  // hamilton product: component c uses a[i] * b[c ^ i]; this gives the subtracted terms
  function automatic logic qr_term_neg(input logic [1:0] c, input logic [1:0] i);
    logic neg;
    case ({c, i})
      4'b0001, 4'b0010, 4'b0011, 4'b0111, 4'b1001, 4'b1110: neg = 1'b1;
      default: neg = 1'b0;
    endcase
    return neg;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/qr_hprod.sv
// three-stage pipelined hamilton product with an arithmetic right shift of each sum
`default_nettype none

module qr_hprod #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int SH = 30,
  parameter int RW = 36
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire logic                      adv_i,
  input  wire logic [3:0][AW-1:0]        a_i,
  input  wire logic [3:0][BW-1:0]        b_i,
  output logic      [3:0][RW-1:0]        r_o,
  output qr_pkg::qr_stage_t              st_o
);

  // operand a is split in a low unsigned half and a high signed half
  localparam int H  = AW / 2;
  localparam int HW = AW - H;
  localparam int PW = AW + BW;
  localparam int SW = PW + 2;

  logic signed [H+BW:0]    lo_d [4][4];
  logic signed [HW+BW-1:0] hi_d [4][4];
  logic signed [H+BW:0]    lo_q [4][4];
  logic signed [HW+BW-1:0] hi_q [4][4];
  logic signed [PW-1:0]    m_d  [4][4];
  logic signed [PW-1:0]    m_q  [4][4];
  logic signed [SW-1:0]    s_d  [4];
  logic        [RW-1:0]    r_d  [4];
  logic        [RW-1:0]    r_q  [4];

  logic v_p_q, v_m_q, v_s_q;
  logic en_p, en_m, en_s;

  // a stage loads when it is empty or its content moves on
  assign en_s = !v_s_q || adv_i;
  assign en_m = !v_m_q || en_s;
  assign en_p = !v_p_q || en_m;

  assign st_o = '{en_p: en_p, en_m: en_m, en_s: en_s, v_p: v_p_q, v_m: v_m_q, v_s: v_s_q};

  // partial products, one pair per term
  for (genvar c = 0; c < 4; c++) begin : g_comp
    for (genvar i = 0; i < 4; i++) begin : g_term
      localparam int J = c ^ i;
      assign lo_d[c][i] = $signed({1'b0, a_i[i][H-1:0]}) * $signed(b_i[J]);
      assign hi_d[c][i] = $signed(a_i[i][AW-1:H]) * $signed(b_i[J]);
      assign m_d[c][i]  = (PW'(hi_q[c][i]) <<< H) + PW'(lo_q[c][i]);
    end
    assign r_d[c] = RW'(s_d[c] >>> SH);
    assign r_o[c] = r_q[c];
  end

  // signed sum of the four terms of each component
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      s_d[c] = '0;
      for (int i = 0; i < 4; i++) begin
        if (qr_pkg::qr_term_neg(2'(c), 2'(i))) begin
          s_d[c] = s_d[c] - SW'(m_q[c][i]);
        end else begin
          s_d[c] = s_d[c] + SW'(m_q[c][i]);
        end
      end
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_p_q <= 1'b0;
      v_m_q <= 1'b0;
      v_s_q <= 1'b0;
    end else begin
      if (en_p) v_p_q <= valid_i;
      if (en_m) v_m_q <= v_p_q;
      if (en_s) v_s_q <= v_m_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_p) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    if (en_m) m_q <= m_d;
    if (en_s) r_q <= r_d;
  end

endmodule

`default_nettype wire

FILE: rtl/qr_sat.sv
// saturation to the field width and the output register
`default_nettype none

module qr_sat #(
  parameter int TW = 40
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire logic [3:0][TW-1:0]    t_i,
  output logic                       adv_o,
  output logic                       valid_o,
  input  wire logic                  stall_i,
  output qr_pkg::qr_out_t            data_o
);

  localparam int W = qr_pkg::DATA_WIDTH;

  logic [3:0][W-1:0] comp;
  logic [3:0]        ovf;
  qr_pkg::qr_out_t   data_d, data_q;
  logic              valid_q;

  // clamp each component
  for (genvar c = 0; c < 4; c++) begin : g_comp
    if (TW > W) begin : g_clamp
      logic fits;
      assign fits    = (&t_i[c][TW-1:W-1]) || !(|t_i[c][TW-1:W-1]);
      assign ovf[c]  = !fits;
      assign comp[c] = fits ? t_i[c][W-1:0]
                     : (t_i[c][TW-1] ? qr_pkg::SAT_MIN : qr_pkg::SAT_MAX);
    end else begin : g_extend
      assign ovf[c]  = 1'b0;
      assign comp[c] = W'($signed(t_i[c]));
    end
  end

  assign data_d = '{out_real: comp[0], out_i: comp[1], out_j: comp[2], out_k: comp[3],
                    overflow: |ovf};

  // output register loads when empty or taken
  assign adv_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/quaternion_rotate_top.sv
// Rotates a point by a quaternion pair: result = (left x point) x right, saturated.
// One beat is accepted every clock while in_stall_o is low. A beat passes through two
// three-stage hamilton product pipelines, each with a split multiplier stage, a
// recombine stage and a sum/shift stage, and then through the saturating output
// register. Throughput is set by the fully pipelined array of 64 partial
// multipliers. Stalls collapse bubbles stage by stage, so in_stall_o rises only when
// all seven stages hold a beat and out_stall_i is high. Left and right quaternions are
// signed with ROT_FRAC_BITS fraction bits; point and result are signed Q16.16, and
// overflow marks a beat in which any component was clamped.
`default_nettype none

module quaternion_rotate_top #(
  parameter int ROT_FRAC_BITS = qr_pkg::ROT_FRAC_BITS
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire qr_pkg::qr_in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output qr_pkg::qr_out_t      out_data_o
);

  localparam int W   = qr_pkg::DATA_WIDTH;
  localparam int SW1 = 2 * W + 2;
  localparam int TW1 = (SW1 > ROT_FRAC_BITS) ? SW1 - ROT_FRAC_BITS : 1;
  localparam int SW2 = TW1 + W + 2;
  localparam int TW2 = (SW2 > ROT_FRAC_BITS) ? SW2 - ROT_FRAC_BITS : 1;

  logic [3:0][W-1:0]   lq, pq, rq;
  logic [3:0][W-1:0]   rq_q [3];
  logic [3:0][TW1-1:0] tq;
  logic [3:0][TW2-1:0] yq;
  qr_pkg::qr_stage_t   st1, st2;
  logic                sat_adv;

  // unpack the input beat
  assign lq = {in_data_i.left_k,  in_data_i.left_j,  in_data_i.left_i,  in_data_i.left_real};
  assign pq = {in_data_i.point_k, in_data_i.point_j, in_data_i.point_i, in_data_i.point_real};
  assign rq = {in_data_i.right_k, in_data_i.right_j, in_data_i.right_i, in_data_i.right_real};

  assign in_stall_o = !st1.en_p;

  // first product: left x point
  qr_hprod #(.AW(W), .BW(W), .SH(ROT_FRAC_BITS), .RW(TW1)) u_prod_lp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .adv_i   (st2.en_p),
    .a_i     (lq),
    .b_i     (pq),
    .r_o     (tq),
    .st_o    (st1)
  );

  // right quaternion rides along with the first product
  always_ff @(posedge clk_i) begin
    if (st1.en_p) rq_q[0] <= rq;
    if (st1.en_m) rq_q[1] <= rq_q[0];
    if (st1.en_s) rq_q[2] <= rq_q[1];
  end

  // second product: t x right
  qr_hprod #(.AW(TW1), .BW(W), .SH(ROT_FRAC_BITS), .RW(TW2)) u_prod_tr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (st1.v_s),
    .adv_i   (sat_adv),
    .a_i     (tq),
    .b_i     (rq_q[2]),
    .r_o     (yq),
    .st_o    (st2)
  );

  // clamp and output register
  qr_sat #(.TW(TW2)) u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (st2.v_s),
    .t_i     (yq),
    .adv_o   (sat_adv),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

  // input stalls only with every stage full and the output blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (st1.v_p && st1.v_m && st1.v_s && st2.v_p && st2.v_m && st2.v_s &&
                    out_valid_o && out_stall_i))
    else $error("input stalled with a bubble in the pipeline");

  // a free output never backs up to the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is free");

  // overflow beats carry at least one clamped component
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.overflow) |->
      (out_data_o.out_real == qr_pkg::SAT_MAX || out_data_o.out_real == qr_pkg::SAT_MIN ||
       out_data_o.out_i == qr_pkg::SAT_MAX || out_data_o.out_i == qr_pkg::SAT_MIN ||
       out_data_o.out_j == qr_pkg::SAT_MAX || out_data_o.out_j == qr_pkg::SAT_MIN ||
       out_data_o.out_k == qr_pkg::SAT_MAX || out_data_o.out_k == qr_pkg::SAT_MIN))
    else $error("overflow set without a clamped component");

  // a result only appears from a valid last product stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(st2.v_s))
    else $error("output valid without a beat from the second product");

endmodule

`default_nettype wire
